// ----- rtl/core/pdc_pkg.sv -----
// Shared types and constants for the proof-of-work difficulty check core.
// Used by pdc_front, pdc_queue, pdc_back and pow_difficulty_check_core.
package pdc_pkg;

	localparam int unsigned WordWidth       = 64;
	localparam int unsigned EdgeWidth       = 8;
	localparam int unsigned ScaleWidth      = 32;
	localparam int unsigned CfgDataWidth    = 6;
	localparam int unsigned CfgIndexWidth   = 2;
	localparam int unsigned QueueDepth      = 2;
	localparam int unsigned QueuePtrWidth   = $clog2(QueueDepth);
	localparam int unsigned QueueCountWidth = $clog2(QueueDepth + 1);
	localparam int unsigned DivSteps        = WordWidth;

	localparam logic [CfgIndexWidth-1:0] CfgIdxSecondary = 2'd0;
	localparam logic [CfgIndexWidth-1:0] CfgIdxBase      = 2'd1;

	localparam logic [CfgDataWidth-1:0] SecondaryReset = 6'd29;
	localparam logic [CfgDataWidth-1:0] BaseReset      = 6'd24;

	typedef enum logic [1:0] {
		StOk            = 2'd0,
		StNotIncreasing = 2'd1,
		StExceeds       = 2'd2,
		StBadEdge       = 2'd3
	} status_t;

	typedef struct packed {
		logic [WordWidth-1:0] s;
		logic [WordWidth-1:0] h;
		logic [WordWidth-1:0] target;
		logic                 not_inc;
		logic                 bad;
	} work_item_t;

	typedef struct packed {
		logic [WordWidth-1:0] r;
		logic [WordWidth-1:0] q;
		logic [WordWidth-1:0] h;
		logic [WordWidth-1:0] target;
		logic                 not_inc;
		logic                 bad;
		logic                 sat;
	} div_item_t;

	typedef struct packed {
		logic push;
		logic full;
	} queue_ctrl_t;

endpackage

// ----- rtl/core/pdc_front.sv -----
// Front end: holds the secondary and base edge-bit registers, classifies each request
// and forms the scaling numerator and the difficulty rise. Depends on pdc_pkg.
module pdc_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic [pdc_pkg::WordWidth-1:0]        total_difficulty,
	input  logic [pdc_pkg::WordWidth-1:0]        prev_total_difficulty,
	input  logic [pdc_pkg::EdgeWidth-1:0]        edge_bits,
	input  logic [pdc_pkg::ScaleWidth-1:0]       scaling_difficulty,
	input  logic [pdc_pkg::WordWidth-1:0]        hash_word,
	input  logic                                 cfg_valid,
	input  logic [pdc_pkg::CfgIndexWidth-1:0]    cfg_index,
	input  logic [pdc_pkg::CfgDataWidth-1:0]     cfg_data,
	input  logic                                 queue_full,
	output pdc_pkg::queue_ctrl_t                 qctrl,
	output pdc_pkg::work_item_t                  item
);

	logic [pdc_pkg::CfgDataWidth-1:0] secondary_q;
	logic [pdc_pkg::CfgDataWidth-1:0] base_q;
	logic                             is_secondary;
	logic                             below_base;
	logic [pdc_pkg::EdgeWidth:0]      edge_diff;
	logic                             bad_edge;
	logic [pdc_pkg::CfgDataWidth:0]   shift_amt;
	logic [pdc_pkg::WordWidth-1:0]    primary_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			secondary_q <= pdc_pkg::SecondaryReset;
			base_q      <= pdc_pkg::BaseReset;
		end else if (cfg_valid) begin
			case (cfg_index)
				pdc_pkg::CfgIdxSecondary: secondary_q <= cfg_data;
				pdc_pkg::CfgIdxBase:      base_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		is_secondary = edge_bits == {2'b00, secondary_q};
		below_base   = edge_bits < {2'b00, base_q};
		edge_diff    = {1'b0, edge_bits} - {3'b000, base_q};
		bad_edge     = !is_secondary && (below_base || (edge_diff[7:6] != 2'b00));
		shift_amt    = {1'b0, edge_diff[5:0]} + 7'd1;
		primary_s    = {{(pdc_pkg::WordWidth - pdc_pkg::EdgeWidth){1'b0}}, edge_bits}
			<< shift_amt;

		if (is_secondary) begin
			item.s = {{(pdc_pkg::WordWidth - pdc_pkg::ScaleWidth){1'b0}}, scaling_difficulty};
		end else if (bad_edge) begin
			item.s = '0;
		end else begin
			item.s = primary_s;
		end
		item.h       = hash_word;
		item.target  = total_difficulty - prev_total_difficulty;
		item.not_inc = total_difficulty <= prev_total_difficulty;
		item.bad     = bad_edge;

		qctrl.push = in_valid && !queue_full;
		qctrl.full = queue_full;
	end

endmodule

// ----- rtl/core/pdc_queue.sv -----
// Short first-in first-out queue between the front end and the divider.
// Depends on pdc_pkg for the entry type and depth.
module pdc_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  pdc_pkg::work_item_t  push_item,
	input  logic                 pop,
	output pdc_pkg::work_item_t  head,
	output logic                 empty,
	output logic                 full
);

	pdc_pkg::work_item_t                   mem [pdc_pkg::QueueDepth];
	logic [pdc_pkg::QueuePtrWidth-1:0]     wr_ptr_q;
	logic [pdc_pkg::QueuePtrWidth-1:0]     rd_ptr_q;
	logic [pdc_pkg::QueueCountWidth-1:0]   count_q;
	logic                                  do_push;
	logic                                  do_pop;

	assign empty   = count_q == '0;
	assign full    = count_q == pdc_pkg::QueueCountWidth'(pdc_pkg::QueueDepth);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == pdc_pkg::QueuePtrWidth'(pdc_pkg::QueueDepth - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == pdc_pkg::QueuePtrWidth'(pdc_pkg::QueueDepth - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/pdc_back.sv -----
// Back end: a restoring divider pipelined one quotient bit per stage, then the
// saturation, the maximum check and the output register. Depends on pdc_pkg.
module pdc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  pdc_pkg::work_item_t           head,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          valid_res,
	output logic [1:0]                    status,
	output logic [pdc_pkg::WordWidth-1:0] max_difficulty
);

	pdc_pkg::div_item_t                stage_data_q  [pdc_pkg::DivSteps + 1];
	logic                              stage_valid_q [pdc_pkg::DivSteps + 1];
	pdc_pkg::div_item_t                init_item;
	pdc_pkg::div_item_t                last_item;
	logic                              advance;
	logic                              out_valid_q;
	logic                              valid_res_q;
	pdc_pkg::status_t                  status_q;
	logic [pdc_pkg::WordWidth-1:0]     max_q;
	logic [pdc_pkg::WordWidth-1:0]     fin_max;
	pdc_pkg::status_t                  fin_status;

	function automatic pdc_pkg::div_item_t div_step(input pdc_pkg::div_item_t x);
		logic [pdc_pkg::WordWidth:0] rr;
		logic [pdc_pkg::WordWidth:0] hh;
		logic [pdc_pkg::WordWidth:0] rd;
		logic                        ge;
		pdc_pkg::div_item_t          y;
		rr = {x.r, 1'b0};
		hh = {1'b0, x.h};
		rd = rr - hh;
		ge = rr >= hh;
		y = x;
		y.r = ge ? rd[pdc_pkg::WordWidth-1:0] : rr[pdc_pkg::WordWidth-1:0];
		y.q = {x.q[pdc_pkg::WordWidth-2:0], ge};
		return y;
	endfunction

	assign advance = !out_valid_q || !out_stall;
	assign pop     = advance && head_valid;

	always_comb begin
		init_item.r       = head.s;
		init_item.q       = '0;
		init_item.h       = head.h;
		init_item.target  = head.target;
		init_item.not_inc = head.not_inc;
		init_item.bad     = head.bad;
		init_item.sat     = (head.h == '0) || (head.s >= head.h);

		last_item = stage_data_q[pdc_pkg::DivSteps];
		if (last_item.bad) begin
			fin_max = '0;
		end else if (last_item.sat) begin
			fin_max = '1;
		end else begin
			fin_max = last_item.q;
		end
		if (last_item.not_inc) begin
			fin_status = pdc_pkg::StNotIncreasing;
		end else if (last_item.bad) begin
			fin_status = pdc_pkg::StBadEdge;
		end else if (fin_max < last_item.target) begin
			fin_status = pdc_pkg::StExceeds;
		end else begin
			fin_status = pdc_pkg::StOk;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= pdc_pkg::DivSteps; i++) begin
				stage_valid_q[i] <= 1'b0;
			end
			out_valid_q <= 1'b0;
		end else if (advance) begin
			stage_valid_q[0] <= head_valid;
			for (int i = 1; i <= pdc_pkg::DivSteps; i++) begin
				stage_valid_q[i] <= stage_valid_q[i-1];
			end
			out_valid_q <= stage_valid_q[pdc_pkg::DivSteps];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			stage_data_q[0] <= init_item;
			for (int i = 1; i <= pdc_pkg::DivSteps; i++) begin
				stage_data_q[i] <= div_step(stage_data_q[i-1]);
			end
			if (stage_valid_q[pdc_pkg::DivSteps]) begin
				max_q       <= fin_max;
				status_q    <= fin_status;
				valid_res_q <= fin_status == pdc_pkg::StOk;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign valid_res      = valid_res_q;
	assign status         = status_q;
	assign max_difficulty = max_q;

endmodule

// ----- rtl/core/pow_difficulty_check_core.sv -----
// Top level of the proof-of-work difficulty check core: front end, queue and
// divider back end. Depends on pdc_pkg, pdc_front, pdc_queue and pdc_back.
//
//   channel  handshake                  payload
//   in       in_valid / in_stall        total_difficulty, prev_total_difficulty,
//                                       edge_bits, scaling_difficulty, hash_word
//   out      out_valid / out_stall      valid_res, status, max_difficulty
//   cfg      cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One request is accepted per cycle and one result leaves per cycle when the
// output is not stalled. After acceptance a request waits in the queue, then
// passes through 64 divider stages and the output register.
// Reset empties the queue, clears the stage valid bits and loads the edge-bit registers with their reset values.
// A stalled output freezes the divider; the two-entry queue then fills and raises in_stall.
module pow_difficulty_check_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [pdc_pkg::WordWidth-1:0]       total_difficulty,
	input  logic [pdc_pkg::WordWidth-1:0]       prev_total_difficulty,
	input  logic [pdc_pkg::EdgeWidth-1:0]       edge_bits,
	input  logic [pdc_pkg::ScaleWidth-1:0]      scaling_difficulty,
	input  logic [pdc_pkg::WordWidth-1:0]       hash_word,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                valid_res,
	output logic [1:0]                          status,
	output logic [pdc_pkg::WordWidth-1:0]       max_difficulty,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pdc_pkg::CfgIndexWidth-1:0]   cfg_index,
	input  logic [pdc_pkg::CfgDataWidth-1:0]    cfg_data
);

	pdc_pkg::queue_ctrl_t qctrl;
	pdc_pkg::work_item_t  front_item;
	pdc_pkg::work_item_t  head_item;
	logic                 q_empty;
	logic                 q_full;
	logic                 q_pop;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;

	pdc_front u_front (
		.clk                   (clk),
		.arst_n                (arst_n),
		.in_valid              (in_valid),
		.total_difficulty      (total_difficulty),
		.prev_total_difficulty (prev_total_difficulty),
		.edge_bits             (edge_bits),
		.scaling_difficulty    (scaling_difficulty),
		.hash_word             (hash_word),
		.cfg_valid             (cfg_valid && cfg_ready),
		.cfg_index             (cfg_index),
		.cfg_data              (cfg_data),
		.queue_full            (q_full),
		.qctrl                 (qctrl),
		.item                  (front_item)
	);

	pdc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (qctrl.push),
		.push_item (front_item),
		.pop       (q_pop),
		.head      (head_item),
		.empty     (q_empty),
		.full      (q_full)
	);

	pdc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (!q_empty),
		.head           (head_item),
		.pop            (q_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.valid_res      (valid_res),
		.status         (status),
		.max_difficulty (max_difficulty)
	);

	a_accept_fills_queue: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !q_empty)
		else $error("Accepted request did not reach the queue.");

	a_bad_edge_zero_max: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == pdc_pkg::StBadEdge) |-> (max_difficulty == '0))
		else $error("Bad edge bits reported with a non-zero maximum.");

	a_valid_matches_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (valid_res == (status == pdc_pkg::StOk)))
		else $error("Validity flag disagrees with status.");

	a_stall_only_when_queue_full: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_full) |=> !in_stall)
		else $error("Queue stayed full after a pop with no push.");

endmodule
